### rtl/cklt_pkg.sv
package cklt_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int KEY_BYTES_DEF = 8;

   localparam int KEY_W = 64;
   localparam int TAG_W = 64;
   localparam int AMT_W = 32;
   localparam int CNT_W = 5;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]        key;
      logic [TAG_W-1:0]        tag;
      logic signed [AMT_W-1:0] amount;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN_RD  = 6'b000010,
      S_SCAN_CHK = 6'b000100,
      S_SHIFT_RD = 6'b001000,
      S_SHIFT_WR = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

endpackage

### rtl/cklt_if.sv
interface cklt_req_if;
   import cklt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic [KEY_W-1:0]        key;
   logic [TAG_W-1:0]        kind_tag;
   logic signed [AMT_W-1:0] amount;

   modport source (output valid, action, key, kind_tag, amount, input ready);
   modport sink   (input valid, action, key, kind_tag, amount, output ready);
endinterface

interface cklt_rsp_if;
   import cklt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [TAG_W-1:0]        found_tag;
   logic signed [AMT_W-1:0] found_amount;
   logic [CNT_W-1:0]        entry_count;

   modport source (output valid, status, found_tag, found_amount, entry_count, input ready);
   modport sink   (input valid, status, found_tag, found_amount, entry_count, output ready);
endinterface

### rtl/cklt_ram.sv
module cklt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/compacting_keyed_list_table_unit.sv
// Keyed list table: up to CAPACITY entries of key, kind tag and amount, kept in
// arrival order in one synchronous RAM.
// The req channel carries one word per request: add, remove by key or search by
// key. The rsp channel returns exactly one word per request with a status, the
// tag and amount of a search hit (zero otherwise) and the count after the request.
// Add, requests on an empty table and the unused action code go straight from
// acceptance to the response. A search or remove reads the entries in order
// from the first and compares each key with the request; a search stops at the
// first hit, and a miss reads all n entries. A remove of entry p then moves each
// later entry one place down, a read and then a write per entry, and responds.
// One request is processed at a time. A finished response waits in an output
// register, and the next request is accepted while it waits; the block only
// stalls when a second response is ready before the first was taken.
// Reset clears the entry count and the handshake state; the RAM is not cleared,
// since only entries below the count are ever read.
module compacting_keyed_list_table_unit #(
   parameter int CAPACITY  = cklt_pkg::CAPACITY_DEF,
   parameter int KEY_BYTES = cklt_pkg::KEY_BYTES_DEF
) (
   input logic      clock,
   input logic      reset,
   cklt_req_if.sink   req_if,
   cklt_rsp_if.source rsp_if
);
   import cklt_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam logic [KEY_W-1:0] TEXT_MASK = {KEY_W{1'b1}} >> (8 * (8 - KEY_BYTES));

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [1:0]              action_ff, action_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [1:0]              status_ff, status_in;
   logic [TAG_W-1:0]        hit_tag_ff, hit_tag_in;
   logic signed [AMT_W-1:0] hit_amt_ff, hit_amt_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic signed [AMT_W-1:0] rsp_amt_ff, rsp_amt_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic             req_fire;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_entry;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;
   entry_type        rd_entry;
   logic [CW-1:0]    idx_plus1;
   logic [CW-1:0]    idx_plus2;
   logic             rsp_free;

   cklt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY),
      .AW    (IDX_W)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_entry  = entry_type'(mem_rd_data);
   assign idx_plus1 = CW'(idx_ff) + CW'(1);
   assign idx_plus2 = CW'(idx_ff) + CW'(2);
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found_tag    = rsp_tag_ff;
   assign rsp_if.found_amount = rsp_amt_ff;
   assign rsp_if.entry_count  = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      action_in     = action_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      hit_tag_in    = hit_tag_ff;
      hit_amt_in    = hit_amt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_amt_in    = rsp_amt_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_entry  = rd_entry;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in  = req_if.action;
               key_in     = req_if.key & TEXT_MASK;
               status_in  = ST_OK;
               hit_tag_in = '0;
               hit_amt_in = '0;
               idx_in     = '0;
               state_in   = S_RESP;
               if (req_if.action == ACT_ADD) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     // Append at the end of the list.
                     mem_wr_en           = 1'b1;
                     mem_wr_addr         = count_ff[IDX_W-1:0];
                     mem_wr_entry.key    = req_if.key & TEXT_MASK;
                     mem_wr_entry.tag    = req_if.kind_tag & TEXT_MASK;
                     mem_wr_entry.amount = req_if.amount;
                     count_in            = count_ff + CW'(1);
                  end
               end else if (req_if.action == ACT_REMOVE || req_if.action == ACT_SEARCH) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (rd_entry.key == key_ff) begin
               if (action_ff == ACT_SEARCH) begin
                  hit_tag_in = rd_entry.tag;
                  hit_amt_in = rd_entry.amount;
                  state_in   = S_RESP;
               end else if (idx_plus1 < count_ff) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_RESP;
               end
            end else if (idx_plus1 == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_plus1[IDX_W-1:0];
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // Move the entry that was just read one place down.
            mem_wr_en    = 1'b1;
            mem_wr_addr  = idx_ff;
            mem_wr_entry = rd_entry;
            idx_in       = idx_ff + IDX_W'(1);
            if (idx_plus2 < count_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_tag_in    = hit_tag_ff;
               rsp_amt_in    = hit_amt_ff;
               rsp_count_in  = CNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      hit_tag_ff    <= hit_tag_in;
      hit_amt_ff    <= hit_amt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_amt_ff    <= rsp_amt_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

### tb/compacting_keyed_list_table_unit_test.sv
`timescale 1ns / 100ps

module compacting_keyed_list_table_unit_test;
   import cklt_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (8 * (8 - KEY_BYTES_DEF));
   localparam logic [KEY_W-1:0] KEY_ALL = {KEY_W{1'b1}};
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam bit USE_PREDICTOR = 1'b0;
   localparam bit TYPED_REPLY = 1'b1;
   localparam int DIRECTED_ROWS = 15;
   localparam int KEY_POOL = 10;
   localparam int ITEMS_PER_PHASE = 475;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0]              action;
      logic [KEY_W-1:0]        key;
      logic [TAG_W-1:0]        kind_tag;
      logic signed [AMT_W-1:0] amount;
   } table_request_t;

   typedef struct packed {
      logic [1:0]              status;
      logic [TAG_W-1:0]        found_tag;
      logic signed [AMT_W-1:0] found_amount;
      logic [CNT_W-1:0]        entry_count;
   } table_reply_t;

   typedef struct packed {
      table_request_t item;
      logic [4:0]     times;
      logic           typed;
      table_reply_t   reply;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cklt_req_if req_ch ();
   cklt_rsp_if rsp_ch ();

   compacting_keyed_list_table_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table contents.
   logic [KEY_W-1:0]        stored_keys [CAPACITY];
   logic [TAG_W-1:0]        stored_tags [CAPACITY];
   logic signed [AMT_W-1:0] stored_amounts [CAPACITY];
   int                      stored_count = 0;

   table_reply_t pending_replies [$];
   int           mismatch_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  stall_pct = 0;

   function automatic table_reply_t predict_table_reply(table_request_t item);
      table_reply_t     reply;
      logic [KEY_W-1:0] wanted;
      int               hit;
      reply = '0;
      wanted = item.key & KEY_MASK;
      hit = -1;
      if (item.action == ACT_ADD) begin
         if (stored_count >= CAPACITY) begin
            reply.status = ST_FULL;
         end else begin
            stored_keys[stored_count] = wanted;
            stored_tags[stored_count] = item.kind_tag & KEY_MASK;
            stored_amounts[stored_count] = item.amount;
            stored_count++;
         end
      end else if (item.action == ACT_REMOVE || item.action == ACT_SEARCH) begin
         if (stored_count == 0) begin
            reply.status = ST_EMPTY;
         end else begin
            // Walk down so that the lowest matching index wins.
            for (int i = stored_count - 1; i >= 0; i--) begin
               if (stored_keys[i] == wanted) hit = i;
            end
            if (hit < 0) begin
               reply.status = ST_NOT_FOUND;
            end else if (item.action == ACT_SEARCH) begin
               reply.found_tag = stored_tags[hit];
               reply.found_amount = stored_amounts[hit];
            end else begin
               for (int j = hit; j < stored_count - 1; j++) begin
                  stored_keys[j] = stored_keys[j + 1];
                  stored_tags[j] = stored_tags[j + 1];
                  stored_amounts[j] = stored_amounts[j + 1];
               end
               stored_count--;
            end
         end
      end
      reply.entry_count = stored_count[CNT_W-1:0];
      return reply;
   endfunction

   // Called right after a rising edge; returns at the edge that accepts the word.
   task automatic send_request(input table_request_t item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= item.action;
      req_ch.key <= item.key;
      req_ch.kind_tag <= item.kind_tag;
      req_ch.amount <= item.amount;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_replies();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   initial begin
      directed_row_t    directed_rows [DIRECTED_ROWS];
      logic [KEY_W-1:0] key_pool [KEY_POOL];
      table_request_t   item;
      table_reply_t     predicted;
      int unsigned      add_pct;
      int unsigned      pick;

      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_ADD;
      req_ch.key <= '0;
      req_ch.kind_tag <= '0;
      req_ch.amount <= '0;

      directed_rows = '{
         '{'{ACT_SEARCH, 64'h0, 64'h0, 32'h0}, 5'd1, TYPED_REPLY,
           '{ST_EMPTY, 64'h0, 32'h0, 5'd0}},
         '{'{ACT_REMOVE, KEY_ALL, 64'h0, 32'h0}, 5'd1, TYPED_REPLY,
           '{ST_EMPTY, 64'h0, 32'h0, 5'd0}},
         '{'{ACT_UNUSED, 64'h0, KEY_ALL, 32'hFFFF_FFFF}, 5'd1, TYPED_REPLY,
           '{ST_OK, 64'h0, 32'h0, 5'd0}},
         '{'{ACT_ADD, 64'h0, 64'h0, 32'h8000_0000}, 5'd1, TYPED_REPLY,
           '{ST_OK, 64'h0, 32'h0, 5'd1}},
         '{'{ACT_ADD, KEY_ALL, KEY_ALL, 32'h7FFF_FFFF}, 5'd1, TYPED_REPLY,
           '{ST_OK, 64'h0, 32'h0, 5'd2}},
         '{'{ACT_ADD, KEY_ALL, 64'h1111, 32'h5}, 5'd1, TYPED_REPLY,
           '{ST_OK, 64'h0, 32'h0, 5'd3}},
         '{'{ACT_SEARCH, KEY_ALL, 64'h0, 32'h0}, 5'd1, TYPED_REPLY,
           '{ST_OK, KEY_ALL, 32'h7FFF_FFFF, 5'd3}},
         '{'{ACT_SEARCH, 64'h1234, 64'h0, 32'h0}, 5'd1, TYPED_REPLY,
           '{ST_NOT_FOUND, 64'h0, 32'h0, 5'd3}},
         '{'{ACT_REMOVE, 64'h0, 64'h0, 32'h0}, 5'd1, USE_PREDICTOR, '0},
         '{'{ACT_REMOVE, KEY_ALL, 64'h0, 32'h0}, 5'd1, USE_PREDICTOR, '0},
         '{'{ACT_SEARCH, KEY_ALL, 64'h0, 32'h0}, 5'd1, USE_PREDICTOR, '0},
         '{'{ACT_ADD, 64'hA5, 64'h5A, 32'hFFFF_FFFF}, 5'd15, USE_PREDICTOR, '0},
         '{'{ACT_ADD, 64'h77, 64'h1, 32'h1}, 5'd1, TYPED_REPLY,
           '{ST_FULL, 64'h0, 32'h0, 5'd16}},
         '{'{ACT_REMOVE, KEY_ALL, 64'h0, 32'h0}, 5'd1, USE_PREDICTOR, '0},
         '{'{ACT_UNUSED, 64'hA5, 64'h0, 32'h0}, 5'd1, USE_PREDICTOR, '0}
      };

      key_pool[0] = 64'h0;
      key_pool[1] = KEY_ALL;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         for (int n = 0; n < directed_rows[r].times; n++) begin
            send_request(directed_rows[r].item);
            predicted = predict_table_reply(directed_rows[r].item);
            pending_replies.push_back(directed_rows[r].typed ? directed_rows[r].reply
                                                             : predicted);
         end
      end
      wait_for_replies();

      add_pct = 50;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Swing the add share so the table fills up and drains out in turn.
            if (n % 60 == 0) add_pct = 20 + 25 * $urandom_range(2);
            pick = $urandom_range(99);
            if (pick < 3) item.action = ACT_UNUSED;
            else if (pick < 3 + add_pct) item.action = ACT_ADD;
            else if (pick % 2 == 0) item.action = ACT_REMOVE;
            else item.action = ACT_SEARCH;
            if ($urandom_range(9) < 8) item.key = key_pool[$urandom_range(KEY_POOL - 1)];
            else item.key = {$urandom, $urandom};
            item.kind_tag = {$urandom, $urandom};
            item.amount = $urandom;
            send_request(item);
            pending_replies.push_back(predict_table_reply(item));
         end
         wait_for_replies();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      table_reply_t wanted_reply;
      table_reply_t seen_reply;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            seen_reply = '{rsp_ch.status, rsp_ch.found_tag, rsp_ch.found_amount,
                           rsp_ch.entry_count};
            if (pending_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected result word: status %0d tag %h amount %0d count %0d",
                           seen_reply.status, seen_reply.found_tag,
                           seen_reply.found_amount, seen_reply.entry_count);
               end
            end else begin
               wanted_reply = pending_replies.pop_front();
               if (seen_reply.status !== wanted_reply.status
                   || seen_reply.found_tag !== wanted_reply.found_tag
                   || seen_reply.found_amount !== wanted_reply.found_amount
                   || seen_reply.entry_count !== wanted_reply.entry_count) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("result mismatch at %0t: expected status %0d tag %h amount %0d count %0d",
                              $realtime, wanted_reply.status, wanted_reply.found_tag,
                              wanted_reply.found_amount, wanted_reply.entry_count);
                     $display("                         got status %0d tag %h amount %0d count %0d",
                              seen_reply.status, seen_reply.found_tag,
                              seen_reply.found_amount, seen_reply.entry_count);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // A correct run ends well inside one millisecond; this is many times that.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
